// ===== sv/pisp_pkg.sv =====
`default_nettype none

package pisp_pkg;

  localparam int MAX_STREAMS_DEF = 4;
  localparam int PSD_FIELDS      = 4;

  localparam int TIME_W     = 64;
  localparam int FREQ_W     = 40;
  localparam int BW_LO_W    = 20;
  localparam int PSD_W      = 32;
  localparam int POWER_W    = 64;
  localparam int PRODUCT_W  = PSD_W + FREQ_W;
  localparam int PART_W     = 3;
  localparam int COUNT_W    = 3;
  localparam int STATUS_W   = 3;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_INDEX_W = 2;
  localparam int OUT_DEPTH  = 8;

  localparam logic [PART_W-1:0] PART_WHOLE = '0;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SENSITIVITY,
    REG_CHECK_ENABLE,
    REG_REQUESTED_PART
  } cfg_reg_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK,
    ST_LOW_POWER,
    ST_DETECT_FAIL,
    ST_NO_CELLS,
    ST_COUNT_CHANGE
  } status_t;

  // Per-cell control fields carried down the front pipeline
  typedef struct packed {
    logic                valid;
    logic [PART_W-1:0]   part;
    logic [TIME_W-1:0]   start_time;
    logic [TIME_W-1:0]   end_time;
    logic                detect_ok;
    logic [COUNT_W-1:0]  stream_count;
    logic                last_cell;
  } cell_ctl_t;

  typedef struct packed {
    logic zero;
    logic add;
    logic last;
  } lane_ctrl_t;

  typedef struct packed {
    logic    pass;
    status_t status;
  } verdict_t;

endpackage

`default_nettype wire

// ===== sv/pisp_cell_if.sv =====
`default_nettype none

interface pisp_cell_if import pisp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [PART_W-1:0]   cell_part;
  logic [TIME_W-1:0]   start_time;
  logic [TIME_W-1:0]   end_time;
  logic [FREQ_W-1:0]   lower_freq;
  logic [FREQ_W-1:0]   upper_freq;
  logic                detect_ok;
  logic [COUNT_W-1:0]  stream_count;
  logic [PSD_W-1:0]    psd_a;
  logic [PSD_W-1:0]    psd_b;
  logic [PSD_W-1:0]    psd_c;
  logic [PSD_W-1:0]    psd_d;
  logic                last_cell;

  modport source (
    output valid, cell_part, start_time, end_time, lower_freq, upper_freq,
           detect_ok, stream_count, psd_a, psd_b, psd_c, psd_d, last_cell,
    input  ready
  );

  modport sink (
    input  valid, cell_part, start_time, end_time, lower_freq, upper_freq,
           detect_ok, stream_count, psd_a, psd_b, psd_c, psd_d, last_cell,
    output ready
  );
endinterface

`default_nettype wire

// ===== sv/pisp_verdict_if.sv =====
`default_nettype none

interface pisp_verdict_if import pisp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                pass;
  logic [STATUS_W-1:0] status;

  modport source (output valid, pass, status, input ready);
  modport sink   (input valid, pass, status, output ready);
endinterface

`default_nettype wire

// ===== sv/per_interval_stream_power_check_unit.sv =====
// Channel     Dir  Handshake      Carries
// grid_cell   in   valid/ready    one resource cell: part, times, edges, psd per stream
// verdict     out  valid/ready    pass flag and status, one per reception
// cfg_*       in   write enable   sensitivity, check_enable, requested_part
//
// One cell is taken every cycle while cell ready is high. A verdict follows
// its last cell through registers: edge bandwidth registered at the accept
// edge, then split multiply, product merge, interval update in the lanes,
// then the verdict compare into an 8-entry queue.
// The interval update and per-stream accumulate close in the same cycle.
// Reset clears the reception state and the queue; no clearing pass.
// Cell ready drops only when 8 verdicts are pending, queued or in flight.
`default_nettype none

module per_interval_stream_power_check_unit import pisp_pkg::*; #(
  parameter int MAX_STREAMS = MAX_STREAMS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  pisp_cell_if.sink                   grid_cell,
  pisp_verdict_if.source              verdict,
  input  wire logic                   cfg_wr_en,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [POWER_W-1:0]     sensitivity;
  logic                   check_enable;
  logic [PART_W-1:0]      requested_part;

  logic                   cell_acc;
  logic                   in_space;
  cell_ctl_t              s1_ctl;
  cell_ctl_t              s2_ctl;
  cell_ctl_t              s3_ctl;
  logic [FREQ_W-1:0]      bw;
  logic [FREQ_W-1:0]      s1_bw;
  logic [PSD_W-1:0]       s1_psd [PSD_FIELDS];
  logic [PSD_W-1:0]       lane_psd [MAX_STREAMS];
  lane_ctrl_t             lane_ctrl [MAX_STREAMS];
  logic [MAX_STREAMS-1:0] meets;
  logic [MAX_STREAMS-1:0] snap_meets;
  logic                   result_valid;
  verdict_t               result;

  always_ff @(posedge clk) begin
    if (rst) begin
      sensitivity    <= '0;
      check_enable   <= 1'b1;
      requested_part <= PART_WHOLE;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_SENSITIVITY:    sensitivity    <= cfg_data;
        REG_CHECK_ENABLE:   check_enable   <= cfg_data[0];
        REG_REQUESTED_PART: requested_part <= cfg_data[PART_W-1:0];
        default: ;
      endcase
    end
  end

  assign grid_cell.ready = in_space;
  assign cell_acc        = grid_cell.valid && grid_cell.ready;
  assign bw = (grid_cell.upper_freq > grid_cell.lower_freq) ?
              grid_cell.upper_freq - grid_cell.lower_freq : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl <= '0;
      s2_ctl <= '0;
      s3_ctl <= '0;
    end else begin
      s1_ctl.valid        <= cell_acc;
      s1_ctl.part         <= grid_cell.cell_part;
      s1_ctl.start_time   <= grid_cell.start_time;
      s1_ctl.end_time     <= grid_cell.end_time;
      s1_ctl.detect_ok    <= grid_cell.detect_ok;
      s1_ctl.stream_count <= grid_cell.stream_count;
      s1_ctl.last_cell    <= grid_cell.last_cell;
      s2_ctl              <= s1_ctl;
      s3_ctl              <= s2_ctl;
    end
  end

  always_ff @(posedge clk) begin
    s1_bw     <= bw;
    s1_psd[0] <= grid_cell.psd_a;
    s1_psd[1] <= grid_cell.psd_b;
    s1_psd[2] <= grid_cell.psd_c;
    s1_psd[3] <= grid_cell.psd_d;
  end

  for (genvar s = 0; s < MAX_STREAMS; s++) begin : g_lane
    if (s < PSD_FIELDS) begin : g_psd
      assign lane_psd[s] = s1_psd[s];
    end else begin : g_nopsd
      assign lane_psd[s] = '0;
    end

    pisp_lane u_lane (
      .clk         (clk),
      .rst         (rst),
      .psd         (lane_psd[s]),
      .bw          (s1_bw),
      .ctrl        (lane_ctrl[s]),
      .sensitivity (sensitivity),
      .meets       (meets[s]),
      .snap_meets  (snap_meets[s])
    );
  end

  pisp_tracker #(
    .MAX_STREAMS (MAX_STREAMS)
  ) u_tracker (
    .clk            (clk),
    .rst            (rst),
    .ctl            (s3_ctl),
    .requested_part (requested_part),
    .check_enable   (check_enable),
    .meets          (meets),
    .snap_meets     (snap_meets),
    .lane_ctrl      (lane_ctrl),
    .result_valid   (result_valid),
    .result         (result)
  );

  pisp_out_queue #(
    .DEPTH (OUT_DEPTH)
  ) u_out_queue (
    .clk     (clk),
    .rst     (rst),
    .reserve (cell_acc && grid_cell.last_cell),
    .wr_en   (result_valid),
    .wr_data (result),
    .space   (in_space),
    .verdict (verdict)
  );

endmodule

`default_nettype wire

// ===== sv/pisp_lane.sv =====
`default_nettype none

module pisp_lane import pisp_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [PSD_W-1:0]   psd,
  input  wire logic [FREQ_W-1:0]  bw,
  input  wire lane_ctrl_t         ctrl,
  input  wire logic [POWER_W-1:0] sensitivity,
  output logic                    meets,
  output logic                    snap_meets
);

  localparam int BW_HI_W = FREQ_W - BW_LO_W;
  localparam int PP_LO_W = PSD_W + BW_LO_W;
  localparam int PP_HI_W = PSD_W + BW_HI_W;

  logic [PP_LO_W-1:0]   pp_lo;
  logic [PP_HI_W-1:0]   pp_hi;
  logic [PRODUCT_W-1:0] full;
  logic [POWER_W-1:0]   product;
  logic [POWER_W-1:0]   power;
  logic [POWER_W-1:0]   power_next;
  logic [POWER_W-1:0]   snap;
  logic [POWER_W-1:0]   base;
  logic [POWER_W:0]     sum;

  // two partial products, recombined into the product register
  always_ff @(posedge clk) begin
    pp_lo <= PP_LO_W'(psd) * PP_LO_W'(bw[BW_LO_W-1:0]);
    pp_hi <= PP_HI_W'(psd) * PP_HI_W'(bw[FREQ_W-1:BW_LO_W]);
  end

  assign full = PRODUCT_W'(pp_lo) + PRODUCT_W'({pp_hi, BW_LO_W'(0)});

  always_ff @(posedge clk) begin
    product <= (|full[PRODUCT_W-1:POWER_W]) ? '1 : full[POWER_W-1:0];
  end

  always_comb begin
    base = ctrl.zero ? '0 : power;
    sum  = {1'b0, base} + {1'b0, product};
    if (ctrl.add) begin
      power_next = sum[POWER_W] ? '1 : sum[POWER_W-1:0];
    end else begin
      power_next = base;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.last) begin
      power <= '0;
    end else begin
      power <= power_next;
    end
  end

  // hold the reception's final power for the verdict stage
  always_ff @(posedge clk) begin
    if (ctrl.last) begin
      snap <= power_next;
    end
  end

  assign meets      = power >= sensitivity;
  assign snap_meets = snap >= sensitivity;

endmodule

`default_nettype wire

// ===== sv/pisp_tracker.sv =====
`default_nettype none

module pisp_tracker import pisp_pkg::*; #(
  parameter int MAX_STREAMS = MAX_STREAMS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire cell_ctl_t              ctl,
  input  wire logic [PART_W-1:0]      requested_part,
  input  wire logic                   check_enable,
  input  wire logic [MAX_STREAMS-1:0] meets,
  input  wire logic [MAX_STREAMS-1:0] snap_meets,
  output lane_ctrl_t                  lane_ctrl [MAX_STREAMS],
  output logic                        result_valid,
  output verdict_t                    result
);

  localparam logic [COUNT_W-1:0] CNT_MAX =
    COUNT_W'(MAX_STREAMS < PSD_FIELDS ? MAX_STREAMS : PSD_FIELDS);

  logic [TIME_W-1:0]  interval_start;
  logic [TIME_W-1:0]  interval_end;
  logic [COUNT_W-1:0] active_streams;
  logic               any_found;
  status_t            fail_code;

  logic [TIME_W-1:0]  interval_start_next;
  logic [TIME_W-1:0]  interval_end_next;
  logic [COUNT_W-1:0] active_streams_next;
  logic               any_found_next;
  status_t            fail_code_next;

  logic               snap_valid;
  logic [COUNT_W-1:0] snap_active;
  logic               snap_any;
  status_t            snap_fail;

  logic               counted;
  logic               restart;
  logic               meets_all;
  logic               snap_all;
  logic [COUNT_W-1:0] cnt_sat;
  logic [COUNT_W-1:0] act_base;
  logic               zero;
  logic               add;
  logic               last;
  status_t            code;

  assign counted = ctl.valid && (fail_code == ST_OK) &&
                   (requested_part == PART_WHOLE || ctl.part == requested_part);
  assign restart = (active_streams == '0) || (ctl.start_time != interval_start) ||
                   (ctl.end_time != interval_end);
  assign cnt_sat = (ctl.stream_count > CNT_MAX) ? CNT_MAX : ctl.stream_count;
  assign last    = ctl.valid && ctl.last_cell;

  always_comb begin
    meets_all = active_streams != '0;
    snap_all  = snap_active != '0;
    for (int s = 0; s < MAX_STREAMS; s++) begin
      if (COUNT_W'(s) < active_streams && !meets[s]) meets_all = 1'b0;
      if (COUNT_W'(s) < snap_active && !snap_meets[s]) snap_all = 1'b0;
    end
  end

  always_comb begin
    interval_start_next = interval_start;
    interval_end_next   = interval_end;
    active_streams_next = active_streams;
    any_found_next      = any_found;
    fail_code_next      = fail_code;
    act_base            = active_streams;
    zero                = 1'b0;
    add                 = 1'b0;
    if (counted) begin
      any_found_next = 1'b1;
      if (restart && active_streams != '0 && !meets_all) begin
        fail_code_next = ST_LOW_POWER;
      end else begin
        // open a new interval: drop the old sums
        if (restart) begin
          interval_start_next = ctl.start_time;
          interval_end_next   = ctl.end_time;
          act_base            = '0;
          zero                = 1'b1;
        end
        active_streams_next = act_base;
        if (!ctl.detect_ok || ctl.stream_count == '0) begin
          fail_code_next = ST_DETECT_FAIL;
        end else if (act_base != '0 && act_base != cnt_sat) begin
          fail_code_next = ST_COUNT_CHANGE;
        end else begin
          active_streams_next = cnt_sat;
          add                 = 1'b1;
        end
      end
    end
  end

  always_comb begin
    for (int s = 0; s < MAX_STREAMS; s++) begin
      lane_ctrl[s].zero = zero;
      lane_ctrl[s].add  = add && (COUNT_W'(s) < cnt_sat);
      lane_ctrl[s].last = last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || last) begin
      interval_start <= '0;
      interval_end   <= '0;
      active_streams <= '0;
      any_found      <= 1'b0;
      fail_code      <= ST_OK;
    end else begin
      interval_start <= interval_start_next;
      interval_end   <= interval_end_next;
      active_streams <= active_streams_next;
      any_found      <= any_found_next;
      fail_code      <= fail_code_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else begin
      snap_valid <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (last) begin
      snap_active <= active_streams_next;
      snap_any    <= any_found_next;
      snap_fail   <= fail_code_next;
    end
  end

  always_comb begin
    priority if (!check_enable) begin
      code = ST_OK;
    end else if (snap_fail != ST_OK) begin
      code = snap_fail;
    end else if (!snap_any) begin
      code = ST_NO_CELLS;
    end else if (!snap_all) begin
      code = ST_LOW_POWER;
    end else begin
      code = ST_OK;
    end
  end

  assign result_valid  = snap_valid;
  assign result.pass   = code == ST_OK;
  assign result.status = code;

endmodule

`default_nettype wire

// ===== sv/pisp_out_queue.sv =====
`default_nettype none

module pisp_out_queue import pisp_pkg::*; #(
  parameter int DEPTH = OUT_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       reserve,
  input  wire logic       wr_en,
  input  wire verdict_t   wr_data,
  output logic            space,
  pisp_verdict_if.source  verdict
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  verdict_t           mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   fill;
  logic [CNT_W-1:0]   credit;
  logic               pop;

  assign pop = verdict.valid && verdict.ready;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // credit counts every request whose verdict is in flight or queued
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
      credit <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      fill   <= fill + CNT_W'(wr_en) - CNT_W'(pop);
      credit <= credit + CNT_W'(reserve) - CNT_W'(pop);
    end
  end

  assign space          = credit != CNT_W'(DEPTH);
  assign verdict.valid  = fill != '0;
  assign verdict.pass   = mem[rd_ptr].pass;
  assign verdict.status = mem[rd_ptr].status;

endmodule

`default_nettype wire

// ===== sv/pisp_checker.sv =====
`default_nettype none

module pisp_checker import pisp_pkg::*; (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                cell_valid,
  input wire logic                cell_ready,
  input wire logic                cell_last,
  input wire logic                verdict_valid,
  input wire logic                verdict_ready,
  input wire logic                verdict_pass,
  input wire logic [STATUS_W-1:0] verdict_status
);

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !verdict_valid)
    else $error("verdict valid right after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    verdict_valid && !verdict_ready |=> verdict_valid)
    else $error("stalled verdict dropped");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    verdict_valid && !verdict_ready |=> $stable({verdict_pass, verdict_status}))
    else $error("stalled verdict changed");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(verdict_valid) |-> $past(cell_valid && cell_ready && cell_last, 5))
    else $error("verdict without a last cell five cycles earlier");

  a_pass_status: assert property (@(posedge clk) disable iff (rst)
    verdict_valid |-> (verdict_pass == (verdict_status == ST_OK)))
    else $error("pass flag disagrees with status");

endmodule

bind per_interval_stream_power_check_unit pisp_checker u_pisp_checker (
  .clk            (clk),
  .rst            (rst),
  .cell_valid     (grid_cell.valid),
  .cell_ready     (grid_cell.ready),
  .cell_last      (grid_cell.last_cell),
  .verdict_valid  (verdict.valid),
  .verdict_ready  (verdict.ready),
  .verdict_pass   (verdict.pass),
  .verdict_status (verdict.status)
);

`default_nettype wire
